@@ design/yuv420_block_to_rgb_defines.svh @@
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_defines.svh
// Assertion macros shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef YUV420_BLOCK_TO_RGB_DEFINES_SVH
`define YUV420_BLOCK_TO_RGB_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every edge while out of reset.
`define YB2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define YB2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define YB2R_ASSERT(lbl, prop, msg)
`define YB2R_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/yb2r_pkg.sv @@
// ----------------------------------------------------------------------------
// yb2r_pkg
// Types, register codes and constants of the 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
package yb2r_pkg;

  localparam int COEF_W = 12;
  localparam int DIFF_W = 9;               // sample minus offset, signed
  localparam int PROD_W = COEF_W + DIFF_W; // coefficient times difference
  localparam int SUM_W  = PROD_W + 2;      // three products summed

  localparam logic [DIFF_W-1:0] LUMA_OFFSET   = 9'd16;
  localparam logic [DIFF_W-1:0] CHROMA_OFFSET = 9'd128;
  localparam logic [7:0]        ALPHA_OPAQUE  = 8'd255;
  localparam logic [7:0]        PIX_MAX       = 8'd255;

  typedef enum logic [1:0] {
    LAYOUT_RGB  = 2'd0,
    LAYOUT_BGR  = 2'd1,
    LAYOUT_RGBA = 2'd2,
    LAYOUT_BGRA = 2'd3
  } layout_t;

  typedef enum logic [2:0] {
    REG_LUMA_GAIN   = 3'd0,
    REG_CB_TO_RED   = 3'd1,
    REG_CR_TO_RED   = 3'd2,
    REG_CB_TO_GREEN = 3'd3,
    REG_CR_TO_GREEN = 3'd4,
    REG_CB_TO_BLUE  = 3'd5,
    REG_CR_TO_BLUE  = 3'd6,
    REG_OUT_LAYOUT  = 3'd7
  } cfg_idx_t;

  localparam logic signed [COEF_W-1:0] RST_LUMA_GAIN   = 12'sd298;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_RED   = 12'sd0;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_RED   = 12'sd409;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_GREEN = -12'sd100;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_GREEN = -12'sd208;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_BLUE  = 12'sd516;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_BLUE  = 12'sd0;

  typedef struct packed {
    logic signed [COEF_W-1:0] luma_gain;
    logic signed [COEF_W-1:0] cb_to_red;
    logic signed [COEF_W-1:0] cr_to_red;
    logic signed [COEF_W-1:0] cb_to_green;
    logic signed [COEF_W-1:0] cr_to_green;
    logic signed [COEF_W-1:0] cb_to_blue;
    logic signed [COEF_W-1:0] cr_to_blue;
    layout_t                  layout;
  } cfg_t;

  // One pixel request from the block splitter to the pixel pipeline.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       row;
    logic       col;
    logic       block_done;
    logic       frame_done;
  } pix_req_t;

endpackage

@@ design/yb2r_cfg.sv @@
// ----------------------------------------------------------------------------
// yb2r_cfg
// Coefficient and layout registers behind the configuration write port.
// ----------------------------------------------------------------------------
module yb2r_cfg
  import yb2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_LUMA_GAIN:   cfg_nxt.luma_gain   = cfg_data;
        REG_CB_TO_RED:   cfg_nxt.cb_to_red   = cfg_data;
        REG_CR_TO_RED:   cfg_nxt.cr_to_red   = cfg_data;
        REG_CB_TO_GREEN: cfg_nxt.cb_to_green = cfg_data;
        REG_CR_TO_GREEN: cfg_nxt.cr_to_green = cfg_data;
        REG_CB_TO_BLUE:  cfg_nxt.cb_to_blue  = cfg_data;
        REG_CR_TO_BLUE:  cfg_nxt.cr_to_blue  = cfg_data;
        REG_OUT_LAYOUT:  cfg_nxt.layout      = layout_t'(cfg_data[1:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_gain   <= RST_LUMA_GAIN;
      cfg_r.cb_to_red   <= RST_CB_TO_RED;
      cfg_r.cr_to_red   <= RST_CR_TO_RED;
      cfg_r.cb_to_green <= RST_CB_TO_GREEN;
      cfg_r.cr_to_green <= RST_CR_TO_GREEN;
      cfg_r.cb_to_blue  <= RST_CB_TO_BLUE;
      cfg_r.cr_to_blue  <= RST_CR_TO_BLUE;
      cfg_r.layout      <= LAYOUT_RGB;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/yb2r_split.sv @@
// ----------------------------------------------------------------------------
// yb2r_split
// Holds one 2x2 block and hands its four pixels to the pipeline in raster order.
// ----------------------------------------------------------------------------
`include "yuv420_block_to_rgb_defines.svh"

module yb2r_split
  import yb2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_chroma_red,
  input  logic [7:0] in_luma_top_left,
  input  logic [7:0] in_luma_top_right,
  input  logic [7:0] in_luma_bottom_left,
  input  logic [7:0] in_luma_bottom_right,
  input  logic       in_final_block,
  output logic       req_valid,
  input  logic       req_ready,
  output pix_req_t   req
);

  logic       blk_valid_r, blk_valid_nxt;
  logic [1:0] k_r, k_nxt;
  logic [7:0] cb_r, cr_r;
  logic [7:0] luma_r [4];
  logic       fin_r;
  logic       fire, last, accept;

  assign fire     = blk_valid_r && req_ready;
  assign last     = (k_r == 2'd3);
  // a new block may land in the same cycle the last pixel leaves
  assign in_stall = blk_valid_r && !(fire && last);
  assign accept   = in_valid && !in_stall;

  assign req_valid      = blk_valid_r;
  assign req.luma       = luma_r[k_r];
  assign req.cb         = cb_r;
  assign req.cr         = cr_r;
  assign req.row        = k_r[1];
  assign req.col        = k_r[0];
  assign req.block_done = last;
  assign req.frame_done = last && fin_r;

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    k_nxt         = k_r;
    if (accept) begin
      blk_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end else if (fire) begin
      blk_valid_nxt = !last;
      k_nxt         = k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cb_r      <= in_chroma_blue;
      cr_r      <= in_chroma_red;
      luma_r[0] <= in_luma_top_left;
      luma_r[1] <= in_luma_top_right;
      luma_r[2] <= in_luma_bottom_left;
      luma_r[3] <= in_luma_bottom_right;
      fin_r     <= in_final_block;
    end
  end

  `YB2R_ASSERT(a_split_hold, blk_valid_r && !req_ready |=> blk_valid_r && $stable(k_r), "pixel index moved while stalled")
  `YB2R_ASSERT(a_split_start, in_valid && !in_stall |=> blk_valid_r && k_r == 2'd0, "new block did not start at top-left")
  `YB2R_ASSERT(a_split_frame, req_valid && req.frame_done |-> req.row && req.col, "frame end flagged before last pixel")

endmodule

@@ design/yb2r_pipe.sv @@
// ----------------------------------------------------------------------------
// yb2r_pipe
// Per-pixel datapath: products, sums, then shift/clamp and byte ordering.
// ----------------------------------------------------------------------------
`include "yuv420_block_to_rgb_defines.svh"

module yb2r_pipe
  import yb2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       req_valid,
  output logic       req_ready,
  input  pix_req_t   req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_lane0,
  output logic [7:0] out_byte_lane1,
  output logic [7:0] out_byte_lane2,
  output logic [7:0] out_byte_lane3,
  output logic [2:0] out_lane_count,
  output logic       out_pixel_row,
  output logic       out_pixel_col,
  output logic       out_block_done,
  output logic       out_frame_done
);

  typedef struct packed {
    logic row;
    logic col;
    logic block_done;
    logic frame_done;
  } tag_t;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] x);
    return SUM_W'(x);
  endfunction

  // floor(v / 256) clamped to 0..255
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
    logic [7:0] res;
    if (v[SUM_W-1])
      res = 8'd0;
    else if (|v[SUM_W-2:16])
      res = PIX_MAX;
    else
      res = v[15:8];
    return res;
  endfunction

  // handshake chain
  logic s1_valid_r, s1_valid_nxt, s2_valid_r, s2_valid_nxt, out_valid_r, out_valid_nxt;
  logic s1_en, s2_en, out_en;

  // stage 1: products
  logic signed [DIFF_W-1:0] d_y, d_cb, d_cr;
  logic signed [PROD_W-1:0] py_r, pcb_r_r, pcr_r_r, pcb_g_r, pcr_g_r, pcb_b_r, pcr_b_r;
  tag_t                     s1_tag_r;

  // stage 2: sums
  logic signed [SUM_W-1:0] sum_r_r, sum_g_r, sum_b_r;
  tag_t                    s2_tag_r;

  // stage 3: formatted pixel
  logic [7:0] red, green, blue;
  logic       swap, four;
  logic [7:0] lane0_r, lane1_r, lane2_r, lane3_r;
  logic [2:0] count_r;
  tag_t       out_tag_r;

  assign out_en    = !out_valid_r || !out_stall;
  assign s2_en     = !s2_valid_r || out_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign req_ready = s1_en;

  always_comb begin
    s1_valid_nxt  = s1_en  ? req_valid  : s1_valid_r;
    s2_valid_nxt  = s2_en  ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_en ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign d_y  = $signed({1'b0, req.luma}) - $signed(LUMA_OFFSET);
  assign d_cb = $signed({1'b0, req.cb})   - $signed(CHROMA_OFFSET);
  assign d_cr = $signed({1'b0, req.cr})   - $signed(CHROMA_OFFSET);

  always_ff @(posedge clk) begin
    if (s1_en && req_valid) begin
      py_r     <= PROD_W'(cfg.luma_gain)   * PROD_W'(d_y);
      pcb_r_r  <= PROD_W'(cfg.cb_to_red)   * PROD_W'(d_cb);
      pcr_r_r  <= PROD_W'(cfg.cr_to_red)   * PROD_W'(d_cr);
      pcb_g_r  <= PROD_W'(cfg.cb_to_green) * PROD_W'(d_cb);
      pcr_g_r  <= PROD_W'(cfg.cr_to_green) * PROD_W'(d_cr);
      pcb_b_r  <= PROD_W'(cfg.cb_to_blue)  * PROD_W'(d_cb);
      pcr_b_r  <= PROD_W'(cfg.cr_to_blue)  * PROD_W'(d_cr);
      s1_tag_r <= '{row: req.row, col: req.col, block_done: req.block_done,
                    frame_done: req.frame_done};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      sum_r_r  <= ext(py_r) + ext(pcb_r_r) + ext(pcr_r_r);
      sum_g_r  <= ext(py_r) + ext(pcb_g_r) + ext(pcr_g_r);
      sum_b_r  <= ext(py_r) + ext(pcb_b_r) + ext(pcr_b_r);
      s2_tag_r <= s1_tag_r;
    end
  end

  always_comb begin
    red   = clamp8(sum_r_r);
    green = clamp8(sum_g_r);
    blue  = clamp8(sum_b_r);
    unique case (cfg.layout)
      LAYOUT_RGB:  begin swap = 1'b0; four = 1'b0; end
      LAYOUT_BGR:  begin swap = 1'b1; four = 1'b0; end
      LAYOUT_RGBA: begin swap = 1'b0; four = 1'b1; end
      LAYOUT_BGRA: begin swap = 1'b1; four = 1'b1; end
      default:     begin swap = 1'b0; four = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid_r) begin
      lane0_r   <= swap ? blue : red;
      lane1_r   <= green;
      lane2_r   <= swap ? red : blue;
      lane3_r   <= four ? ALPHA_OPAQUE : 8'd0;
      count_r   <= four ? 3'd4 : 3'd3;
      out_tag_r <= s2_tag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_lane0 = lane0_r;
  assign out_byte_lane1 = lane1_r;
  assign out_byte_lane2 = lane2_r;
  assign out_byte_lane3 = lane3_r;
  assign out_lane_count = count_r;
  assign out_pixel_row  = out_tag_r.row;
  assign out_pixel_col  = out_tag_r.col;
  assign out_block_done = out_tag_r.block_done;
  assign out_frame_done = out_tag_r.frame_done;

  `YB2R_ASSERT_ALWAYS(a_pipe_rst, !rst_n |=> !out_valid, "output valid right after reset")
  `YB2R_ASSERT(a_pipe_done, out_valid && out_block_done |-> out_pixel_row && out_pixel_col, "block end not on bottom-right pixel")
  `YB2R_ASSERT(a_pipe_frame, out_valid && out_frame_done |-> out_block_done, "frame end without block end")
  `YB2R_ASSERT(a_pipe_alpha, out_valid && out_lane_count == 3'd3 |-> out_byte_lane3 == 8'd0, "alpha lane set in three-byte layout")

endmodule

@@ design/yuv420_block_to_rgb.sv @@
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb
// 4:2:0 YCbCr 2x2 block to packed RGB/BGR/RGBA/BGRA pixel converter.
// ----------------------------------------------------------------------------
// Path: a taken block is held in the block holder, and each of its pixels
//   then passes the multiply, sum and output registers in turn.
// Throughput: one pixel per cycle while out_stall stays low; set by the single
//   pixel-wide output channel and the three-stage pixel pipeline behind it.
// Reset (rst_n low, synchronous): empties the block holder and the pipeline
//   and loads the default BT.601 coefficients with RGB layout.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb
  import yb2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // block requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_chroma_blue,
  input  logic [7:0]        in_chroma_red,
  input  logic [7:0]        in_luma_top_left,
  input  logic [7:0]        in_luma_top_right,
  input  logic [7:0]        in_luma_bottom_left,
  input  logic [7:0]        in_luma_bottom_right,
  input  logic              in_final_block,
  // pixel requests
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte_lane0,
  output logic [7:0]        out_byte_lane1,
  output logic [7:0]        out_byte_lane2,
  output logic [7:0]        out_byte_lane3,
  output logic [2:0]        out_lane_count,
  output logic              out_pixel_row,
  output logic              out_pixel_col,
  output logic              out_block_done,
  output logic              out_frame_done,
  // register writes, only while idle
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  cfg_t     cfg;
  pix_req_t req;
  logic     req_valid, req_ready;

  // Coefficients read live; user writes must land only while idle, unenforced.
  yb2r_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Block holder: takes a new block while its last pixel moves on.
  yb2r_split u_split (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_chroma_blue       (in_chroma_blue),
    .in_chroma_red        (in_chroma_red),
    .in_luma_top_left     (in_luma_top_left),
    .in_luma_top_right    (in_luma_top_right),
    .in_luma_bottom_left  (in_luma_bottom_left),
    .in_luma_bottom_right (in_luma_bottom_right),
    .in_final_block       (in_final_block),
    .req_valid            (req_valid),
    .req_ready            (req_ready),
    .req                  (req)
  );

  // Stages: multiply -> sum -> clamp/format (output register).
  // Each stage advances when it is empty or the next one moves.
  yb2r_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_lane0 (out_byte_lane0),
    .out_byte_lane1 (out_byte_lane1),
    .out_byte_lane2 (out_byte_lane2),
    .out_byte_lane3 (out_byte_lane3),
    .out_lane_count (out_lane_count),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_block_done (out_block_done),
    .out_frame_done (out_frame_done)
  );

endmodule

@@ verif/yuv420_block_to_rgb_tb.sv @@
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_tb
// Self-checking bench: 2x2 block requests go in under random idling and
// back-pressure. A local converter predicts the four pixel requests of each
// block, and every pixel taken from the DUT is compared field by field.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_tb;
  import yb2r_pkg::*;

  // One 2x2 block request. luma[0..3] = TL, TR, BL, BR.
  typedef struct packed {
    logic [7:0]      cb;
    logic [7:0]      cr;
    logic [3:0][7:0] luma;
    logic            last_block;
  } block_t;

  // One pixel request as seen on the out_ port.
  typedef struct packed {
    logic [7:0] lane0;
    logic [7:0] lane1;
    logic [7:0] lane2;
    logic [7:0] lane3;
    logic [2:0] lane_count;
    logic       row;
    logic       col;
    logic       block_done;
    logic       frame_done;
  } pixel_t;

  // All DUT inputs start at known values.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_chroma_blue = '0;
  logic [7:0]        in_chroma_red = '0;
  logic [7:0]        in_luma_top_left = '0;
  logic [7:0]        in_luma_top_right = '0;
  logic [7:0]        in_luma_bottom_left = '0;
  logic [7:0]        in_luma_bottom_right = '0;
  logic              in_final_block = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte_lane0;
  logic [7:0]        out_byte_lane1;
  logic [7:0]        out_byte_lane2;
  logic [7:0]        out_byte_lane3;
  logic [2:0]        out_lane_count;
  logic              out_pixel_row;
  logic              out_pixel_col;
  logic              out_block_done;
  logic              out_frame_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // Bench state: register shadow, pixels still owed by the DUT, error count,
  // and the idling knobs some tests set (percent chance per request/cycle).
  cfg_t   regs_now;
  pixel_t pixels_due[$];
  int     mismatches = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  int     rx_hold = 0;

  yuv420_block_to_rgb i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_chroma_blue       (in_chroma_blue),
    .in_chroma_red        (in_chroma_red),
    .in_luma_top_left     (in_luma_top_left),
    .in_luma_top_right    (in_luma_top_right),
    .in_luma_bottom_left  (in_luma_bottom_left),
    .in_luma_bottom_right (in_luma_bottom_right),
    .in_final_block       (in_final_block),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_byte_lane0       (out_byte_lane0),
    .out_byte_lane1       (out_byte_lane1),
    .out_byte_lane2       (out_byte_lane2),
    .out_byte_lane3       (out_byte_lane3),
    .out_lane_count       (out_lane_count),
    .out_pixel_row        (out_pixel_row),
    .out_pixel_col        (out_pixel_col),
    .out_block_done       (out_block_done),
    .out_frame_done       (out_frame_done),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic int sx12(logic [COEF_W-1:0] v);
    return int'($signed(v));
  endfunction

  // Floor divide by 256 (arithmetic shift), then saturate to a byte.
  function automatic logic [7:0] to_byte(int sum);
    int q;
    q = sum >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return PIX_MAX;
    return q[7:0];
  endfunction

  // Work out the four pixels of one accepted block with the current register
  // shadow and queue them in output order TL, TR, BL, BR.
  function automatic void convert_block(block_t blk);
    int         cb, cr, t_r, t_g, t_b, y;
    logic [7:0] r, g, b;
    logic       swap, four;
    pixel_t     px;
    cb   = int'(blk.cb) - int'(CHROMA_OFFSET);
    cr   = int'(blk.cr) - int'(CHROMA_OFFSET);
    t_r  = sx12(regs_now.cb_to_red) * cb + sx12(regs_now.cr_to_red) * cr;
    t_g  = sx12(regs_now.cb_to_green) * cb + sx12(regs_now.cr_to_green) * cr;
    t_b  = sx12(regs_now.cb_to_blue) * cb + sx12(regs_now.cr_to_blue) * cr;
    swap = regs_now.layout inside {LAYOUT_BGR, LAYOUT_BGRA};
    four = regs_now.layout inside {LAYOUT_RGBA, LAYOUT_BGRA};
    for (int k = 0; k < 4; k++) begin
      y = sx12(regs_now.luma_gain) * (int'(blk.luma[k]) - int'(LUMA_OFFSET));
      r = to_byte(y + t_r);
      g = to_byte(y + t_g);
      b = to_byte(y + t_b);
      px.lane0      = swap ? b : r;
      px.lane1      = g;
      px.lane2      = swap ? r : b;
      px.lane3      = four ? ALPHA_OPAQUE : 8'd0;  // three-byte layouts pad with 0
      px.lane_count = four ? 3'd4 : 3'd3;
      px.row        = k[1];
      px.col        = k[0];
      px.block_done = (k == 3);
      px.frame_done = (k == 3) && blk.last_block;
      pixels_due.push_back(px);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // Idle length: mostly none, sometimes short, rarely a long stretch.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(30, 10);
    return $urandom_range(3, 1);
  endfunction

  // Samples lean toward the rails so clamping gets hit often.
  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic block_t rand_block();
    block_t blk;
    blk.cb = rand_sample();
    blk.cr = rand_sample();
    for (int k = 0; k < 4; k++) blk.luma[k] = rand_sample();
    blk.last_block = ($urandom_range(7, 0) == 0);
    return blk;
  endfunction

  // Coefficients: mostly moderate so pixels land inside 0..255, some rails.
  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7, 0))
      0: return 12'h800;   // -2048
      1: return 12'h7ff;   // 2047
      2: return 12'($urandom);
      default: return 12'($signed($urandom_range(1200, 0)) - 600);
    endcase
  endfunction

  function automatic block_t make_block(logic [7:0] cb, logic [7:0] cr,
                                        logic [7:0] tl, logic [7:0] tr,
                                        logic [7:0] bl, logic [7:0] br,
                                        logic last);
    block_t blk;
    blk.cb = cb;
    blk.cr = cr;
    blk.luma[0] = tl;
    blk.luma[1] = tr;
    blk.luma[2] = bl;
    blk.luma[3] = br;
    blk.last_block = last;
    return blk;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. All tasks are entered and left right after a rising edge.
  // --------------------------------------------------------------------------

  // Send one block request. in_valid is left high on return so back-to-back
  // requests need no drop; wait_idle lowers it.
  task automatic send_block(input block_t blk);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_chroma_blue       <= blk.cb;
    in_chroma_red        <= blk.cr;
    in_luma_top_left     <= blk.luma[0];
    in_luma_top_right    <= blk.luma[1];
    in_luma_bottom_left  <= blk.luma[2];
    in_luma_bottom_right <= blk.luma[3];
    in_final_block       <= blk.last_block;
    do @(posedge clk); while (in_stall);
    convert_block(blk);
  endtask

  // Drop in_valid, let every owed pixel drain, then cover the pipe latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write; only called while idle. Shadow follows on acceptance.
  task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LUMA_GAIN:   regs_now.luma_gain   = data;
      REG_CB_TO_RED:   regs_now.cb_to_red   = data;
      REG_CR_TO_RED:   regs_now.cr_to_red   = data;
      REG_CB_TO_GREEN: regs_now.cb_to_green = data;
      REG_CR_TO_GREEN: regs_now.cr_to_green = data;
      REG_CB_TO_BLUE:  regs_now.cb_to_blue  = data;
      REG_CR_TO_BLUE:  regs_now.cr_to_blue  = data;
      REG_OUT_LAYOUT:  regs_now.layout      = layout_t'(data[1:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Layout write with junk in the bits above the 2-bit field.
  task automatic write_layout(input layout_t lay);
    write_reg(REG_OUT_LAYOUT, {10'($urandom), lay});
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] v);
    write_reg(REG_LUMA_GAIN, v);
    write_reg(REG_CB_TO_RED, v);
    write_reg(REG_CR_TO_RED, v);
    write_reg(REG_CB_TO_GREEN, v);
    write_reg(REG_CR_TO_GREEN, v);
    write_reg(REG_CB_TO_BLUE, v);
    write_reg(REG_CR_TO_BLUE, v);
  endtask

  // --------------------------------------------------------------------------
  // Pixel checker and receiver back-pressure
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte_lane0, out_byte_lane1, out_byte_lane2, out_byte_lane3,
              out_lane_count, out_pixel_row, out_pixel_col, out_block_done,
              out_frame_done};
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("byte_lane0", want.lane0, got.lane0);
        check_field("byte_lane1", want.lane1, got.lane1);
        check_field("byte_lane2", want.lane2, got.lane2);
        check_field("byte_lane3", want.lane3, got.lane3);
        check_field("lane_count", want.lane_count, got.lane_count);
        check_field("pixel_row", want.row, got.row);
        check_field("pixel_col", want.col, got.col);
        check_field("block_done", want.block_done, got.block_done);
        check_field("frame_done", want.frame_done, got.frame_done);
      end
    end
    // Stall runs are picked only once the previous run has ended.
    if (rx_hold == 0) rx_hold = pick_gap(rx_stall_pct);
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset coefficients (BT.601) and RGB layout, rails and bit patterns.
  task automatic test_reset_defaults();
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    send_block(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_block(make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_block(make_block(8'd0, 8'd255, 8'd16, 8'd235, 8'd0, 8'd255, 1'b0));
    send_block(make_block(8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0));
    send_block(make_block(8'd128, 8'd128, 8'd16, 8'd235, 8'd128, 8'd64, 1'b1));
    send_block(make_block(8'h55, 8'haa, 8'haa, 8'h55, 8'hff, 8'h00, 1'b0));
    wait_idle();
  endtask

  // Each byte order once; the alpha lane and swap of red/blue follow it.
  task automatic test_layouts();
    layout_t lay;
    for (int i = 0; i < 4; i++) begin
      lay = layout_t'(i);
      write_layout(lay);
      send_block(make_block(8'd0, 8'd255, 8'd235, 8'd16, 8'd100, 8'd200, 1'b0));
      send_block(make_block(8'd255, 8'd0, 8'd200, 8'd100, 8'd16, 8'd235, 1'b1));
      send_block(make_block(8'd90, 8'd240, 8'd82, 8'd82, 8'd82, 8'd82, 1'b0));
      wait_idle();
    end
  endtask

  // All coefficients on either rail: worst-case sums in both directions.
  task automatic test_coef_extremes();
    write_coefs(12'h800);
    send_block(make_block(8'd0, 8'd255, 8'd255, 8'd0, 8'd16, 8'd17, 1'b0));
    send_block(make_block(8'd255, 8'd0, 8'd0, 8'd255, 8'd15, 8'd128, 1'b1));
    wait_idle();
    write_coefs(12'h7ff);
    send_block(make_block(8'd0, 8'd0, 8'd0, 8'd15, 8'd16, 8'd17, 1'b0));
    send_block(make_block(8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd16, 1'b1));
    wait_idle();
  endtask

  // Random blocks over several register settings and idling mixes.
  // Phase 0 goes back to the reset coefficients; phase 1 runs with no idling
  // on either side and pauses halfway until every pixel has drained.
  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(REG_LUMA_GAIN, RST_LUMA_GAIN);
        write_reg(REG_CB_TO_RED, RST_CB_TO_RED);
        write_reg(REG_CR_TO_RED, RST_CR_TO_RED);
        write_reg(REG_CB_TO_GREEN, RST_CB_TO_GREEN);
        write_reg(REG_CR_TO_GREEN, RST_CR_TO_GREEN);
        write_reg(REG_CB_TO_BLUE, RST_CB_TO_BLUE);
        write_reg(REG_CR_TO_BLUE, RST_CR_TO_BLUE);
      end else begin
        for (int r = 0; r < 7; r++) write_reg(cfg_idx_t'(r), rand_coef());
      end
      write_layout(layout_t'($urandom_range(3, 0)));
      tx_idle_pct  = (ph == 1) ? 0 : $urandom_range(50, 10);
      rx_stall_pct = (ph == 1) ? 0 : $urandom_range(50, 10);
      for (int n = 0; n < 20; n++) begin
        if (n == 10 && (ph == 1 || $urandom_range(2, 0) == 0)) wait_idle();
        send_block(rand_block());
      end
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  initial begin
    regs_now = '{RST_LUMA_GAIN, RST_CB_TO_RED, RST_CR_TO_RED, RST_CB_TO_GREEN,
                 RST_CR_TO_GREEN, RST_CB_TO_BLUE, RST_CR_TO_BLUE, LAYOUT_RGB};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_layouts();
    test_coef_extremes();
    test_random_traffic();
    // wait_idle above already covered the drain and the pipe latency
    if (mismatches == 0) begin
      $display("** yuv420_block_to_rgb: PASSED **");
    end else begin
      $display("** yuv420_block_to_rgb: FAILED **");
    end
    $finish;
  end

  // Watchdog: ~120 requests, worst case the longest idle gap plus four pixels
  // each behind the longest stall, finish well within this limit.
  initial begin
    #5000000;
    $display("** yuv420_block_to_rgb: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/yb2r_pkg.sv
design/yb2r_cfg.sv
design/yb2r_split.sv
design/yb2r_pipe.sv
design/yuv420_block_to_rgb.sv
verif/yuv420_block_to_rgb_tb.sv
